// ----- rtl/lerg_pkg.sv -----
// Shared types, constants and helpers of the Laplacian edge RGB stream unit.
// Depends on nothing; lerg_lane and the top unit in rtl use it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package lerg_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int MAX_PIXEL  = 255;

   localparam int PIX_W   = 8;
   localparam int NUM_CH  = 3;
   localparam int DIM_W   = 12;
   localparam int COORD_W = 11;
   localparam int CNT_W   = $clog2(MAX_WIDTH);
   localparam int CNTH_W  = $clog2(MAX_HEIGHT);
   localparam int CMP_W   = ((CNT_W > CNTH_W ? CNT_W : CNTH_W) > DIM_W ?
                             (CNT_W > CNTH_W ? CNT_W : CNTH_W) : DIM_W) + 1;
   localparam int SUM_W   = PIX_W + 4;
   localparam int WIN_N   = 6;
   localparam int COL_N   = 3;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int REG_IDX_W  = 1;

   localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

   typedef logic [NUM_CH-1:0][PIX_W-1:0] pixel_type;

   localparam int LINE_W = 2 * $bits(pixel_type);

   typedef struct packed {
      pixel_type          pix;
      logic [CNT_W-1:0]   x;
      logic [COORD_W-1:0] ocol;
      logic [COORD_W-1:0] orow;
      logic               interior;
      logic               last;
   } stage_type;

   function automatic logic [CMP_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [CMP_W-1:0] maxv);
      logic [CMP_W-1:0] ext;
      ext = CMP_W'(v);
      if (ext < CMP_W'(3)) begin
         return CMP_W'(3);
      end else if (ext > maxv) begin
         return maxv;
      end
      return ext;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/lerg_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the two line stores of the edge unit.
`timescale 1ns / 1ps
`default_nettype none

module lerg_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/lerg_lane.sv -----
// One color lane of the 3x3 Laplacian: eight times the center minus its
// neighbors, clamped to the pixel range. Depends on lerg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lerg_lane (
   input  wire logic [lerg_pkg::PIX_W-1:0] win_pixel [lerg_pkg::WIN_N],
   input  wire logic [lerg_pkg::PIX_W-1:0] col_pixel [lerg_pkg::COL_N],
   output logic      [lerg_pkg::PIX_W-1:0] edge_val
);

   logic        [lerg_pkg::SUM_W-1:0] sum;
   logic        [lerg_pkg::SUM_W-1:0] center9;
   logic signed [lerg_pkg::SUM_W:0]   diff;

   always_comb begin
      sum = '0;
      for (int i = 0; i < lerg_pkg::WIN_N; i++) begin
         sum = sum + lerg_pkg::SUM_W'(win_pixel[i]);
      end
      for (int i = 0; i < lerg_pkg::COL_N; i++) begin
         sum = sum + lerg_pkg::SUM_W'(col_pixel[i]);
      end
      center9 = (lerg_pkg::SUM_W'(win_pixel[4]) << 3) + lerg_pkg::SUM_W'(win_pixel[4]);
      diff = $signed({1'b0, center9}) - $signed({1'b0, sum});
      if (diff < 0) begin
         edge_val = '0;
      end else if (diff > $signed((lerg_pkg::SUM_W + 1)'(lerg_pkg::MAX_PIXEL))) begin
         edge_val = lerg_pkg::PIX_W'(lerg_pkg::MAX_PIXEL);
      end else begin
         edge_val = diff[lerg_pkg::PIX_W-1:0];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/laplacian_edge_rgb_stream_unit.sv -----
// Laplacian edge RGB stream unit: an accepted word passes the first stage
// register, then the output register. One word per cycle is sustained while
// rsp_ready stays high, set by the single read and single write port of the
// shared line store RAM. Reset clears the column and row counters, the 3x3
// window and the pipeline, and loads frame_width 640 and frame_height 480; the
// line stores keep their contents. Depends on lerg_pkg, lerg_ram and lerg_lane.
`timescale 1ns / 1ps
`default_nettype none

module laplacian_edge_rgb_stream_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [lerg_pkg::PIX_W-1:0]         req_in_red,
   input  wire logic [lerg_pkg::PIX_W-1:0]         req_in_green,
   input  wire logic [lerg_pkg::PIX_W-1:0]         req_in_blue,

   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic      [lerg_pkg::PIX_W-1:0]         rsp_out_red,
   output logic      [lerg_pkg::PIX_W-1:0]         rsp_out_green,
   output logic      [lerg_pkg::PIX_W-1:0]         rsp_out_blue,
   output logic      [lerg_pkg::COORD_W-1:0]       rsp_out_col,
   output logic      [lerg_pkg::COORD_W-1:0]       rsp_out_row,
   output logic                                    rsp_frame_done,

   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [lerg_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [lerg_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic      [lerg_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                    pready
);

   localparam int CMP_W  = lerg_pkg::CMP_W;
   localparam int CNT_W  = lerg_pkg::CNT_W;
   localparam int CNTH_W = lerg_pkg::CNTH_W;
   localparam int PIX_W  = lerg_pkg::PIX_W;
   localparam int CRD_W  = lerg_pkg::COORD_W;
   localparam int PIX_B  = $bits(lerg_pkg::pixel_type);

   logic [lerg_pkg::DIM_W-1:0] frame_width_ff, frame_width_in;
   logic [lerg_pkg::DIM_W-1:0] frame_height_ff, frame_height_in;
   logic [lerg_pkg::REG_IDX_W-1:0] reg_idx;
   logic [CMP_W-1:0] w_dim, h_dim;

   logic [CNT_W-1:0]  column_count_ff, column_count_in;
   logic [CNTH_W-1:0] row_count_ff, row_count_in;

   lerg_pkg::stage_type s1_ff, s1_in;
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_move;
   logic                req_accept;

   lerg_pkg::pixel_type window_ff [lerg_pkg::WIN_N];
   lerg_pkg::pixel_type window_in [lerg_pkg::WIN_N];

   logic [lerg_pkg::LINE_W-1:0] ram_rd_data;
   lerg_pkg::pixel_type         line_above_px, line_two_above_px;

   logic [PIX_W-1:0] lane_win [lerg_pkg::NUM_CH][lerg_pkg::WIN_N];
   logic [PIX_W-1:0] lane_col [lerg_pkg::NUM_CH][lerg_pkg::COL_N];
   logic [PIX_W-1:0] lane_out [lerg_pkg::NUM_CH];

   logic                rsp_valid_ff, rsp_valid_in;
   lerg_pkg::pixel_type rsp_pix_ff, rsp_pix_in;
   logic [CRD_W-1:0]    rsp_col_ff, rsp_col_in;
   logic [CRD_W-1:0]    rsp_row_ff, rsp_row_in;
   logic                rsp_done_ff, rsp_done_in;

   logic [CMP_W-1:0] x_ext, y_ext, ocol_ext, orow_ext, col_plus, row_plus;

   // Configuration registers.
   assign pready  = 1'b1;
   assign reg_idx = paddr[lerg_pkg::CSR_ADDR_W-1:2];
   assign w_dim   = lerg_pkg::clamp_dim(frame_width_ff, CMP_W'(lerg_pkg::MAX_WIDTH));
   assign h_dim   = lerg_pkg::clamp_dim(frame_height_ff, CMP_W'(lerg_pkg::MAX_HEIGHT));

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (psel && penable && pwrite && pready) begin
         case (reg_idx)
            lerg_pkg::REG_FRAME_WIDTH: begin
               frame_width_in = pwdata[lerg_pkg::DIM_W-1:0];
            end
            lerg_pkg::REG_FRAME_HEIGHT: begin
               frame_height_in = pwdata[lerg_pkg::DIM_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         lerg_pkg::REG_FRAME_WIDTH: begin
            prdata = lerg_pkg::CSR_DATA_W'(frame_width_ff);
         end
         lerg_pkg::REG_FRAME_HEIGHT: begin
            prdata = lerg_pkg::CSR_DATA_W'(frame_height_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   // Handshake and first stage: position bookkeeping and line store read.
   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_move;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      x_ext    = CMP_W'(column_count_ff);
      y_ext    = CMP_W'(row_count_ff);
      col_plus = x_ext + CMP_W'(1);
      row_plus = y_ext + CMP_W'(1);

      s1_in.pix   = {req_in_red, req_in_green, req_in_blue};
      s1_in.x     = column_count_ff;
      s1_in.interior = 1'b0;
      if (row_count_ff == '0) begin
         ocol_ext = x_ext;
         orow_ext = h_dim - CMP_W'(1);
      end else if (column_count_ff == '0) begin
         ocol_ext = w_dim - CMP_W'(1);
         orow_ext = y_ext - CMP_W'(1);
      end else begin
         ocol_ext = x_ext - CMP_W'(1);
         orow_ext = y_ext - CMP_W'(1);
         s1_in.interior = (ocol_ext >= CMP_W'(1)) && (ocol_ext + CMP_W'(2) <= w_dim) &&
                          (orow_ext >= CMP_W'(1)) && (orow_ext + CMP_W'(2) <= h_dim);
      end
      s1_in.ocol = ocol_ext[CRD_W-1:0];
      s1_in.orow = orow_ext[CRD_W-1:0];

      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      s1_in.last      = 1'b0;
      if (col_plus >= w_dim) begin
         column_count_in = '0;
         if (row_plus >= h_dim) begin
            row_count_in = '0;
            s1_in.last   = 1'b1;
         end else begin
            row_count_in = row_plus[CNTH_W-1:0];
         end
      end else begin
         column_count_in = col_plus[CNT_W-1:0];
      end
      if (!req_accept) begin
         column_count_in = column_count_ff;
         row_count_in    = row_count_ff;
      end

      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // Both line stores share one RAM word: the upper half is two lines up.
   lerg_ram #(
      .WIDTH(lerg_pkg::LINE_W),
      .DEPTH(lerg_pkg::MAX_WIDTH)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (s1_move),
      .wr_addr(s1_ff.x),
      .wr_data({line_above_px, s1_ff.pix}),
      .rd_en  (req_accept),
      .rd_addr(column_count_ff),
      .rd_data(ram_rd_data)
   );

   assign line_two_above_px = ram_rd_data[lerg_pkg::LINE_W-1:PIX_B];
   assign line_above_px     = ram_rd_data[PIX_B-1:0];

   // Second stage: window shift and the three color lanes.
   always_comb begin
      for (int i = 0; i < lerg_pkg::WIN_N; i++) begin
         window_in[i] = window_ff[i];
      end
      if (s1_move) begin
         window_in[0] = window_ff[3];
         window_in[1] = window_ff[4];
         window_in[2] = window_ff[5];
         window_in[3] = line_two_above_px;
         window_in[4] = line_above_px;
         window_in[5] = s1_ff.pix;
      end
   end

   always_comb begin
      for (int c = 0; c < lerg_pkg::NUM_CH; c++) begin
         for (int i = 0; i < lerg_pkg::WIN_N; i++) begin
            lane_win[c][i] = window_ff[i][c];
         end
         lane_col[c][0] = line_two_above_px[c];
         lane_col[c][1] = line_above_px[c];
         lane_col[c][2] = s1_ff.pix[c];
      end
   end

   for (genvar c = 0; c < lerg_pkg::NUM_CH; c++) begin : g_lane
      lerg_lane u_lane (
         .win_pixel(lane_win[c]),
         .col_pixel(lane_col[c]),
         .edge_val (lane_out[c])
      );
   end

   // Merge the lanes into the output register.
   always_comb begin
      rsp_pix_in  = rsp_pix_ff;
      rsp_col_in  = rsp_col_ff;
      rsp_row_in  = rsp_row_ff;
      rsp_done_in = rsp_done_ff;
      if (s1_move) begin
         for (int c = 0; c < lerg_pkg::NUM_CH; c++) begin
            rsp_pix_in[c] = s1_ff.interior ? lane_out[c] : '0;
         end
         rsp_col_in  = s1_ff.ocol;
         rsp_row_in  = s1_ff.orow;
         rsp_done_in = s1_ff.last;
      end
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= lerg_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= lerg_pkg::FRAME_HEIGHT_RESET;
         column_count_ff <= '0;
         row_count_ff    <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < lerg_pkg::WIN_N; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         for (int i = 0; i < lerg_pkg::WIN_N; i++) begin
            window_ff[i] <= window_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= s1_in;
      end
      rsp_pix_ff  <= rsp_pix_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_red    = rsp_pix_ff[2];
   assign rsp_out_green  = rsp_pix_ff[1];
   assign rsp_out_blue   = rsp_pix_ff[0];
   assign rsp_out_col    = rsp_col_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_frame_done = rsp_done_ff;

   // The line store write never lands on the address being read.
   assert property (@(posedge clock) disable iff (reset)
      (s1_move && req_accept) |-> (s1_ff.x != column_count_ff))
      else $error("line store read and write collide");

   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted word did not enter the first stage");

   assert property (@(posedge clock) disable iff (reset)
      (s1_move && !s1_ff.interior) |=>
         (rsp_out_red == '0 && rsp_out_green == '0 && rsp_out_blue == '0))
      else $error("border word carries a nonzero edge value");

   assert property (@(posedge clock) disable iff (reset)
      (req_accept && row_count_ff == '0) |=> !s1_ff.interior)
      else $error("top row word marked interior");

endmodule

`default_nettype wire

// ----- tb/laplacian_edge_rgb_stream_unit_tb.sv -----
// Self-checking testbench for the Laplacian edge RGB stream unit: a directed table of
// small frames, then random frames and register changes, checked by table or predictor.
// Depends on lerg_pkg and laplacian_edge_rgb_stream_unit.
`timescale 1ns / 1ps

module laplacian_edge_rgb_stream_unit_tb;

   localparam int MAX_W      = lerg_pkg::MAX_WIDTH;
   localparam int MAX_H      = lerg_pkg::MAX_HEIGHT;
   localparam int RANDOM_N   = 950;
   localparam int TAIL_START = 850;
   localparam int HOLD_LEN   = 150;
   localparam int QUIET_MAX  = 3000;

   localparam logic [lerg_pkg::CSR_ADDR_W-1:0] ADDR_FRAME_WIDTH =
      {lerg_pkg::REG_FRAME_WIDTH, 2'b00};
   localparam logic [lerg_pkg::CSR_ADDR_W-1:0] ADDR_FRAME_HEIGHT =
      {lerg_pkg::REG_FRAME_HEIGHT, 2'b00};

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [10:0] col;
      logic [10:0] row;
      logic        done;
   } edge_word_t;

   typedef struct packed {
      logic [23:0] pix;
      bit          typed;
      edge_word_t  want;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset;

   logic                               req_valid;
   logic                               req_ready;
   logic [lerg_pkg::PIX_W-1:0]         req_in_red;
   logic [lerg_pkg::PIX_W-1:0]         req_in_green;
   logic [lerg_pkg::PIX_W-1:0]         req_in_blue;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic [lerg_pkg::PIX_W-1:0]         rsp_out_red;
   logic [lerg_pkg::PIX_W-1:0]         rsp_out_green;
   logic [lerg_pkg::PIX_W-1:0]         rsp_out_blue;
   logic [lerg_pkg::COORD_W-1:0]       rsp_out_col;
   logic [lerg_pkg::COORD_W-1:0]       rsp_out_row;
   logic                               rsp_frame_done;
   logic                               psel;
   logic                               penable;
   logic                               pwrite;
   logic [lerg_pkg::CSR_ADDR_W-1:0]    paddr;
   logic [lerg_pkg::CSR_DATA_W-1:0]    pwdata;
   logic [lerg_pkg::CSR_DATA_W-1:0]    prdata;
   logic                               pready;

   laplacian_edge_rgb_stream_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_red     (req_in_red),
      .req_in_green   (req_in_green),
      .req_in_blue    (req_in_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row),
      .rsp_frame_done (rsp_frame_done),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always #10 clock = ~clock;

   // Predictor state.
   logic [11:0]  width_reg;
   logic [11:0]  height_reg;
   logic [23:0]  line_prev [MAX_W];
   logic [23:0]  line_prev2 [MAX_W];
   logic [23:0]  win [6];
   int unsigned  cur_col;
   int unsigned  cur_row;

   edge_word_t   pending_edges [$];
   stim_row_t    directed_rows [$];
   int unsigned  words_seen = 0;
   int unsigned  fail_count = 0;
   int unsigned  push_count = 0;
   bit           quiet_tail = 1'b0;

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%s", msg);
      end
   endfunction

   function automatic int unsigned dim_in_use(input logic [11:0] v, input int unsigned top);
      if (v < 12'd3) begin
         return 3;
      end
      if (v > top) begin
         return top;
      end
      return v;
   endfunction

   function automatic logic [7:0] laplace_channel(input logic [23:0] c0, input logic [23:0] c1,
                                                  input logic [23:0] c2, input int sh);
      int acc;
      int ctr;
      ctr = int'(win[4][sh +: 8]);
      acc = int'(c0[sh +: 8]) + int'(c1[sh +: 8]) + int'(c2[sh +: 8]);
      for (int i = 0; i < 6; i++) begin
         acc += int'(win[i][sh +: 8]);
      end
      acc = 9 * ctr - acc;
      if (acc < 0) begin
         acc = 0;
      end
      if (acc > lerg_pkg::MAX_PIXEL) begin
         acc = lerg_pkg::MAX_PIXEL;
      end
      return 8'(acc);
   endfunction

   task automatic predict_edge(input logic [23:0] pix, output edge_word_t res);
      int unsigned w;
      int unsigned h;
      int unsigned x;
      int unsigned y;
      int unsigned ocol;
      int unsigned orow;
      logic [23:0] c0;
      logic [23:0] c1;
      bit          interior;
      w = dim_in_use(width_reg, MAX_W);
      h = dim_in_use(height_reg, MAX_H);
      x = (cur_col >= MAX_W) ? MAX_W - 1 : cur_col;
      y = cur_row;
      c0 = line_prev2[x];
      c1 = line_prev[x];
      interior = 1'b0;
      if (y == 0) begin
         ocol = x;
         orow = h - 1;
      end else if (x == 0) begin
         ocol = w - 1;
         orow = y - 1;
      end else begin
         ocol = x - 1;
         orow = y - 1;
         interior = (ocol >= 1) && (ocol + 2 <= w) && (orow >= 1) && (orow + 2 <= h);
      end
      res = '0;
      if (interior) begin
         res.red   = laplace_channel(c0, c1, pix, 16);
         res.green = laplace_channel(c0, c1, pix, 8);
         res.blue  = laplace_channel(c0, c1, pix, 0);
      end
      res.col = ocol[10:0];
      res.row = orow[10:0];
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = c0;
      win[4] = c1;
      win[5] = pix;
      line_prev2[x] = c1;
      line_prev[x]  = pix;
      cur_col++;
      if (cur_col >= w) begin
         cur_col = 0;
         cur_row++;
         if (cur_row >= h) begin
            cur_row  = 0;
            res.done = 1'b1;
         end
      end
   endtask

   function automatic void dir_row(input logic [23:0] pix, input bit typed,
                                   input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b, input logic [10:0] c,
                                   input logic [10:0] rw, input logic d);
      stim_row_t s;
      s.pix   = pix;
      s.typed = typed;
      s.want  = '{red: r, green: g, blue: b, col: c, row: rw, done: d};
      directed_rows.push_back(s);
   endfunction

   function automatic logic [11:0] pick_dim(input bit allow_big, input int unsigned small_hi);
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         return 12'($urandom_range(0, 3));
      end
      if (sel == 1 && allow_big) begin
         case ($urandom_range(0, 2))
            0: return 12'd2048;
            1: return 12'd4095;
            default: return 12'($urandom_range(2049, 4094));
         endcase
      end
      if (sel == 2) begin
         return 12'($urandom_range(11, 40));
      end
      return 12'($urandom_range(3, small_hi));
   endfunction

   function automatic logic [7:0] chan_value(input int unsigned style, input logic [7:0] base);
      if (style == 1) begin
         return ($urandom_range(0, 1) == 1) ? 8'hff : 8'h00;
      end
      if (style == 2) begin
         return base + 8'($urandom_range(0, 15));
      end
      return 8'($urandom);
   endfunction

   task automatic push_pixel(input logic [23:0] pix, input edge_word_t want);
      @(negedge clock);
      if (!quiet_tail && ((push_count / 64) % 3 != 2) && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_in_red   <= pix[23:16];
      req_in_green <= pix[15:8];
      req_in_blue  <= pix[7:0];
      pending_edges.push_back(want);
      push_count++;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_edges.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [lerg_pkg::CSR_ADDR_W-1:0] addr, input logic [11:0] v);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= {20'($urandom), v};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == ADDR_FRAME_WIDTH) begin
         width_reg = v;
      end else begin
         height_reg = v;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_check(input logic [lerg_pkg::CSR_ADDR_W-1:0] addr, input logic [11:0] v);
      logic [lerg_pkg::CSR_DATA_W-1:0] got;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== lerg_pkg::CSR_DATA_W'(v)) begin
         note_failure($sformatf("register read at %0d: expected %0d, got %0d", addr, v, got));
      end
   endtask

   // Result checker.
   always @(posedge clock) begin
      edge_word_t got;
      edge_word_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{red: rsp_out_red, green: rsp_out_green, blue: rsp_out_blue,
                 col: rsp_out_col, row: rsp_out_row, done: rsp_frame_done};
         if (pending_edges.size() == 0) begin
            note_failure($sformatf("unexpected result word %0d: r=%02h g=%02h b=%02h col=%0d row=%0d done=%0b",
                                   words_seen, got.red, got.green, got.blue, got.col, got.row,
                                   got.done));
         end else begin
            want = pending_edges.pop_front();
            if (got !== want) begin
               note_failure($sformatf(
                  "word %0d: expected r=%02h g=%02h b=%02h col=%0d row=%0d done=%0b, got r=%02h g=%02h b=%02h col=%0d row=%0d done=%0b",
                  words_seen, want.red, want.green, want.blue, want.col, want.row, want.done,
                  got.red, got.green, got.blue, got.col, got.row, got.done));
            end
         end
         words_seen++;
      end
   end

   // Result receiver, with random back-pressure and one long hold-off.
   initial begin
      int unsigned rx_cycle;
      bit          long_hold_done;
      rsp_ready = 1'b0;
      rx_cycle = 0;
      long_hold_done = 1'b0;
      forever begin
         @(negedge clock);
         rx_cycle++;
         if (!quiet_tail && !long_hold_done && words_seen >= 300) begin
            long_hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_LEN) @(negedge clock);
            rsp_ready <= 1'b1;
         end else if (!quiet_tail && ((rx_cycle / 100) % 4 != 3) && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles with no handshake at all.
   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_MAX) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("FAIL laplacian_edge_rgb_stream_unit");
      $finish;
   end

   initial begin
      edge_word_t  pred;
      int unsigned random_items;
      int unsigned w_now;
      int unsigned h_now;
      int unsigned left;
      int unsigned batch;
      int unsigned style;
      logic [7:0]  base;
      logic [11:0] new_w;
      logic [11:0] new_h;
      logic [23:0] pix;
      bit          big_now;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_in_red   = '0;
      req_in_green = '0;
      req_in_blue  = '0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      width_reg    = lerg_pkg::FRAME_WIDTH_RESET;
      height_reg   = lerg_pkg::FRAME_HEIGHT_RESET;
      for (int i = 0; i < MAX_W; i++) begin
         line_prev[i]  = '0;
         line_prev2[i] = '0;
      end
      for (int i = 0; i < 6; i++) begin
         win[i] = '0;
      end
      cur_col = 0;
      cur_row = 0;
      random_items = 0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_check(ADDR_FRAME_WIDTH, lerg_pkg::FRAME_WIDTH_RESET);
      csr_check(ADDR_FRAME_HEIGHT, lerg_pkg::FRAME_HEIGHT_RESET);
      // Both dimensions below the minimum, so a 3x3 frame is in use.
      csr_write(ADDR_FRAME_WIDTH, 12'd0);
      csr_write(ADDR_FRAME_HEIGHT, 12'd1);
      csr_check(ADDR_FRAME_WIDTH, 12'd0);
      csr_check(ADDR_FRAME_HEIGHT, 12'd1);

      // Bright center on black: the single interior pixel saturates high.
      dir_row(24'h000000, 1, 8'h00, 8'h00, 8'h00, 11'd0, 11'd2, 1'b0);
      dir_row(24'h000000, 1, 8'h00, 8'h00, 8'h00, 11'd1, 11'd2, 1'b0);
      dir_row(24'h000000, 1, 8'h00, 8'h00, 8'h00, 11'd2, 11'd2, 1'b0);
      dir_row(24'h000000, 1, 8'h00, 8'h00, 8'h00, 11'd2, 11'd0, 1'b0);
      dir_row(24'hffffff, 1, 8'h00, 8'h00, 8'h00, 11'd0, 11'd0, 1'b0);
      dir_row(24'h000000, 1, 8'h00, 8'h00, 8'h00, 11'd1, 11'd0, 1'b0);
      dir_row(24'h000000, 1, 8'h00, 8'h00, 8'h00, 11'd2, 11'd1, 1'b0);
      dir_row(24'h000000, 1, 8'h00, 8'h00, 8'h00, 11'd0, 11'd1, 1'b0);
      dir_row(24'h000000, 1, 8'hff, 8'hff, 8'hff, 11'd1, 11'd1, 1'b1);
      // Dark center on white: the interior pixel clamps to zero.
      dir_row(24'hffffff, 1, 8'h00, 8'h00, 8'h00, 11'd0, 11'd2, 1'b0);
      dir_row(24'hffffff, 1, 8'h00, 8'h00, 8'h00, 11'd1, 11'd2, 1'b0);
      dir_row(24'hffffff, 1, 8'h00, 8'h00, 8'h00, 11'd2, 11'd2, 1'b0);
      dir_row(24'hffffff, 1, 8'h00, 8'h00, 8'h00, 11'd2, 11'd0, 1'b0);
      dir_row(24'h000000, 1, 8'h00, 8'h00, 8'h00, 11'd0, 11'd0, 1'b0);
      dir_row(24'hffffff, 1, 8'h00, 8'h00, 8'h00, 11'd1, 11'd0, 1'b0);
      dir_row(24'hffffff, 1, 8'h00, 8'h00, 8'h00, 11'd2, 11'd1, 1'b0);
      dir_row(24'hffffff, 1, 8'h00, 8'h00, 8'h00, 11'd0, 11'd1, 1'b0);
      dir_row(24'hffffff, 1, 8'h00, 8'h00, 8'h00, 11'd1, 11'd1, 1'b1);
      // A partial frame, left open so that the next register change lands mid-frame.
      dir_row(24'h00ff00, 0, '0, '0, '0, '0, '0, 1'b0);
      dir_row(24'hff00ff, 0, '0, '0, '0, '0, '0, 1'b0);
      dir_row(24'h123456, 0, '0, '0, '0, '0, '0, 1'b0);
      dir_row(24'hffff00, 0, '0, '0, '0, '0, '0, 1'b0);
      dir_row(24'h808080, 0, '0, '0, '0, '0, '0, 1'b0);
      dir_row(24'h01fe7f, 0, '0, '0, '0, '0, '0, 1'b0);
      dir_row(24'h0000ff, 0, '0, '0, '0, '0, '0, 1'b0);

      foreach (directed_rows[i]) begin
         predict_edge(directed_rows[i].pix, pred);
         push_pixel(directed_rows[i].pix, directed_rows[i].typed ? directed_rows[i].want : pred);
      end

      while (random_items < RANDOM_N) begin
         drain_results();
         w_now = dim_in_use(width_reg, MAX_W);
         h_now = dim_in_use(height_reg, MAX_H);
         big_now = (w_now > 64) || (h_now > 64);
         if (big_now || $urandom_range(0, 2) != 0) begin
            new_w = pick_dim(!big_now, 10);
            // A wider line is only safe while the first row is still being filled.
            if (dim_in_use(new_w, MAX_W) <= w_now || cur_row == 0) begin
               csr_write(ADDR_FRAME_WIDTH, new_w);
            end
            new_h = pick_dim(!big_now, 8);
            csr_write(ADDR_FRAME_HEIGHT, new_h);
            csr_check(ADDR_FRAME_WIDTH, width_reg);
            csr_check(ADDR_FRAME_HEIGHT, height_reg);
         end
         w_now = dim_in_use(width_reg, MAX_W);
         h_now = dim_in_use(height_reg, MAX_H);
         left = (cur_col < w_now && cur_row < h_now) ?
                (h_now - cur_row) * w_now - cur_col : 0;
         if (left != 0 && left <= 120 && $urandom_range(0, 3) != 0) begin
            batch = left;
         end else begin
            batch = $urandom_range(1, 40);
         end
         style = $urandom_range(0, 2);
         base  = 8'($urandom);
         for (int n = 0; n < batch; n++) begin
            quiet_tail = (random_items >= TAIL_START);
            pix = {chan_value(style, base), chan_value(style, base), chan_value(style, base)};
            predict_edge(pix, pred);
            push_pixel(pix, pred);
            random_items++;
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_edges.size() == 0) begin
         $display("PASS laplacian_edge_rgb_stream_unit");
      end else begin
         $display("FAIL laplacian_edge_rgb_stream_unit");
      end
      $finish;
   end

endmodule
